FILE: rtl/core/bir_pkg.sv
package bir_pkg;

    // Fixed field widths
    localparam int COORD_W  = 10;
    localparam int CHAN_W   = 2;
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int NCH_W    = 3;

    // Opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHAN   = 3'd4;

    // Request sequencer states
    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_MULT    = 13'b0000000000010,
        S_DIVY_GO = 13'b0000000000100,
        S_DIVY    = 13'b0000000001000,
        S_DIVX_GO = 13'b0000000010000,
        S_DIVX    = 13'b0000000100000,
        S_ADDR    = 13'b0000001000000,
        S_READ    = 13'b0000010000000,
        S_RWAIT   = 13'b0000100000000,
        S_HBLEND  = 13'b0001000000000,
        S_VMUL    = 13'b0010000000000,
        S_VSUM    = 13'b0100000000000,
        S_FIN     = 13'b1000000000000
    } state_t;

endpackage

FILE: rtl/core/bilinear_image_resize.sv
// Align-corners bilinear resizer over a planar source image held in one store.
// Input channel (in_valid/in_ready): each word carries opcode, coord_x,
// coord_y, channel and pixel_in. A load word in range writes one source pixel;
// any load yields no result. A request word yields exactly one result word
// (pixel_out, range_error) on the output channel.
// A request runs through a sequencer: product, two source positions from one
// shared restoring divider (NUM_W-bit numerator, NUM_W = 10 + source width
// bits + FRAC_BITS), four reads through the store read port and the blend. One
// request is in flight at a time, and the next word can be taken in the cycle
// the result becomes valid. An out-of-range request goes from S_IDLE straight
// to S_FIN and skips the divider, reads and blend. in_ready is high only while
// the sequencer is idle.
// A finished result sits in the output register; loads are still taken while
// the receiver stalls, and a following request waits before its last step
// until the register is free.
// Reset clears the sequencer and output valid flag, and sets the size registers
// to 128 x 128 source, 416 x 416 destination, 3 channels. The store is not
// cleared; an entry must be loaded before a request reads it. Configuration
// writes take effect at once; the user makes them only while idle, unchecked.
module bilinear_image_resize #(
    parameter int MAX_SRC_DIM  = 128,
    parameter int MAX_DST_DIM  = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int FRAC_BITS    = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [bir_pkg::COORD_W-1:0]    coord_x,
    input  logic [bir_pkg::COORD_W-1:0]    coord_y,
    input  logic [bir_pkg::CHAN_W-1:0]     channel,
    input  logic [bir_pkg::PIX_W-1:0]      pixel_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bir_pkg::PIX_W-1:0]      pixel_out,
    output logic                           range_error
);

    localparam int SW_W   = $clog2(MAX_SRC_DIM + 1);
    localparam int DW_W   = $clog2(MAX_DST_DIM + 1);
    localparam int RW     = $clog2(MAX_SRC_DIM);
    localparam int DEPTH  = MAX_CHANNELS * MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = bir_pkg::COORD_W + SW_W;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int POS_W  = SW_W + FRAC_BITS;
    localparam int WT_W   = FRAC_BITS + 1;
    localparam int HW     = bir_pkg::PIX_W + FRAC_BITS + 1;
    localparam int VW     = HW + WT_W + 1;
    localparam int RES_W  = VW - 2 * FRAC_BITS;
    localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRAC_BITS;

    typedef logic [bir_pkg::PIX_W-1:0] pix_t;

    // configuration registers
    logic [7:0]                  src_width_reg;
    logic [7:0]                  src_height_reg;
    logic [10:0]                 dst_width_reg;
    logic [10:0]                 dst_height_reg;
    logic [bir_pkg::NCH_W-1:0]   num_chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 8'd128;
            src_height_reg <= 8'd128;
            dst_width_reg  <= 11'd416;
            dst_height_reg <= 11'd416;
            num_chan_reg   <= 3'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bir_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[7:0];
                bir_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[7:0];
                bir_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                bir_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_data;
                bir_pkg::CFG_NUM_CHAN:   num_chan_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [SW_W-1:0]           sw, sh;
    logic [DW_W-1:0]           dw, dh;
    logic [bir_pkg::NCH_W-1:0] nc;

    always_comb
    begin
        sw = (src_width_reg == 8'd0) ? SW_W'(1) :
             (32'(src_width_reg) > MAX_SRC_DIM) ? SW_W'(MAX_SRC_DIM) : SW_W'(src_width_reg);
        sh = (src_height_reg == 8'd0) ? SW_W'(1) :
             (32'(src_height_reg) > MAX_SRC_DIM) ? SW_W'(MAX_SRC_DIM) : SW_W'(src_height_reg);
        dw = (dst_width_reg == 11'd0) ? DW_W'(1) :
             (32'(dst_width_reg) > MAX_DST_DIM) ? DW_W'(MAX_DST_DIM) : DW_W'(dst_width_reg);
        dh = (dst_height_reg == 11'd0) ? DW_W'(1) :
             (32'(dst_height_reg) > MAX_DST_DIM) ? DW_W'(MAX_DST_DIM) : DW_W'(dst_height_reg);
        nc = (num_chan_reg == 3'd0) ? 3'd1 :
             (32'(num_chan_reg) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : num_chan_reg;
    end

    // input checks
    logic in_acc, load_ok, req_bad;

    assign in_acc  = in_valid && in_ready;
    assign load_ok = (32'(coord_x) < 32'(sw)) && (32'(coord_y) < 32'(sh))
                     && (3'(channel) < nc);
    assign req_bad = (32'(coord_x) >= 32'(dw)) || (32'(coord_y) >= 32'(dh))
                     || (3'(channel) >= nc);

    function automatic logic [ADDR_W-1:0] store_addr(input int x, input int y, input int c);
        store_addr = ADDR_W'((c * MAX_SRC_DIM + y) * MAX_SRC_DIM + x);
    endfunction

    // sequencer registers
    bir_pkg::state_t state_reg, state_next;
    logic [bir_pkg::COORD_W-1:0] x_reg, y_reg;
    logic [bir_pkg::CHAN_W-1:0]  c_reg;
    logic                        err_reg;
    logic [PROD_W-1:0]           prod_x_reg, prod_y_reg;
    logic [POS_W-1:0]            pos_x_reg, pos_y_reg;
    logic [RW-1:0]               top_row_reg, bot_row_reg, ix0_reg, ix1_reg;
    logic [FRAC_BITS-1:0]        fx_reg, fy_reg;
    logic                        xs_reg, use_bot_reg;
    logic [1:0]                  rd_cnt_reg, rd_tag_reg;
    logic                        rd_vld_reg;
    pix_t                        p_reg [4];
    logic [HW-1:0]               top_v_reg, bot_v_reg;
    logic [VW-1:0]               vt_reg, vb_reg;
    pix_t                        res_reg;
    logic                        out_valid_reg;
    pix_t                        pixel_out_reg;
    logic                        range_error_reg;

    // shared divider
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quo;
    logic [DW_W-1:0]    div_den;
    logic               dmy_zero, dmx_zero;

    assign div_start = (state_reg == bir_pkg::S_DIVY_GO)
                       || (state_reg == bir_pkg::S_DIVX_GO);
    assign div_num = (state_reg == bir_pkg::S_DIVY_GO) ?
                     {prod_y_reg, FRAC_BITS'(0)} : {prod_x_reg, FRAC_BITS'(0)};
    assign div_den = (state_reg == bir_pkg::S_DIVY_GO) ? DW_W'(dh - 1'b1) : DW_W'(dw - 1'b1);
    assign dmy_zero = (dh == DW_W'(1));
    assign dmx_zero = (dw == DW_W'(1));

    bir_divider #(
        .NUM_W(NUM_W),
        .DEN_W(DW_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numerator(div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // store
    logic               st_re;
    logic [ADDR_W-1:0]  st_raddr;
    pix_t               st_rdata;
    logic [RW-1:0]      rd_row, rd_col;

    assign st_re    = (state_reg == bir_pkg::S_READ);
    assign rd_row   = rd_cnt_reg[1] ? bot_row_reg : top_row_reg;
    assign rd_col   = rd_cnt_reg[0] ? ix1_reg : ix0_reg;
    assign st_raddr = store_addr(int'(rd_col), int'(rd_row), int'(c_reg));

    bir_store #(
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .clk  (clk),
        .we   (in_acc && (opcode == bir_pkg::OP_LOAD) && load_ok),
        .waddr(store_addr(int'(coord_x), int'(coord_y), int'(channel))),
        .wdata(pixel_in),
        .re   (st_re),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    // next state
    logic out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bir_pkg::S_IDLE:
            begin
                if (in_acc && (opcode == bir_pkg::OP_REQUEST))
                begin
                    state_next = req_bad ? bir_pkg::S_FIN : bir_pkg::S_MULT;
                end
            end
            bir_pkg::S_MULT:    state_next = bir_pkg::S_DIVY_GO;
            bir_pkg::S_DIVY_GO: state_next = bir_pkg::S_DIVY;
            bir_pkg::S_DIVY:
            begin
                if (div_done)
                begin
                    state_next = bir_pkg::S_DIVX_GO;
                end
            end
            bir_pkg::S_DIVX_GO: state_next = bir_pkg::S_DIVX;
            bir_pkg::S_DIVX:
            begin
                if (div_done)
                begin
                    state_next = bir_pkg::S_ADDR;
                end
            end
            bir_pkg::S_ADDR:    state_next = bir_pkg::S_READ;
            bir_pkg::S_READ:
            begin
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = bir_pkg::S_RWAIT;
                end
            end
            bir_pkg::S_RWAIT:   state_next = bir_pkg::S_HBLEND;
            bir_pkg::S_HBLEND:  state_next = bir_pkg::S_VMUL;
            bir_pkg::S_VMUL:    state_next = bir_pkg::S_VSUM;
            bir_pkg::S_VSUM:    state_next = bir_pkg::S_FIN;
            bir_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = bir_pkg::S_IDLE;
                end
            end
            default:            state_next = bir_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bir_pkg::S_IDLE;
            rd_cnt_reg    <= 2'd0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= st_re;
            if (state_reg == bir_pkg::S_READ)
            begin
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
            end
            else
            begin
                rd_cnt_reg <= 2'd0;
            end
            if ((state_reg == bir_pkg::S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // address step values
    logic [SW_W-1:0] iy_raw, ix_raw;
    logic [SW_W-1:0] iy_c, ix_c;
    logic            xs, use_bot;

    always_comb
    begin
        iy_raw  = pos_y_reg[FRAC_BITS +: SW_W];
        ix_raw  = pos_x_reg[FRAC_BITS +: SW_W];
        iy_c    = (iy_raw >= sh) ? SW_W'(sh - 1'b1) : iy_raw;
        ix_c    = (SW_W'(ix_raw + 1'b1) >= sw) ? SW_W'(sw - 2'd2) : ix_raw;
        xs      = (32'(x_reg) == 32'(dw) - 1) || (sw == SW_W'(1));
        use_bot = !((32'(y_reg) == 32'(dh) - 1) || (sh == SW_W'(1)))
                  && (SW_W'(iy_c + 1'b1) < sh);
    end

    // blend arithmetic
    logic [HW-1:0]    h_top, h_bot;
    logic [VW-1:0]    v_sum;
    logic [RES_W-1:0] v_round;

    always_comb
    begin
        h_top = xs_reg ? (HW'(p_reg[0]) << FRAC_BITS) :
                HW'(HW'(ONE - WT_W'(fx_reg)) * HW'(p_reg[0]) + HW'(fx_reg) * HW'(p_reg[1]));
        h_bot = xs_reg ? (HW'(p_reg[2]) << FRAC_BITS) :
                HW'(HW'(ONE - WT_W'(fx_reg)) * HW'(p_reg[2]) + HW'(fx_reg) * HW'(p_reg[3]));
        v_sum   = vt_reg + vb_reg + (VW'(1) << (2 * FRAC_BITS - 1));
        v_round = v_sum[VW-1 -: RES_W];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg   <= coord_x;
            y_reg   <= coord_y;
            c_reg   <= channel;
            err_reg <= req_bad;
        end
        if (state_reg == bir_pkg::S_MULT)
        begin
            prod_x_reg <= PROD_W'(x_reg) * PROD_W'(sw - 1'b1);
            prod_y_reg <= PROD_W'(y_reg) * PROD_W'(sh - 1'b1);
        end
        if ((state_reg == bir_pkg::S_DIVY) && div_done)
        begin
            pos_y_reg <= dmy_zero ? '0 : POS_W'(div_quo);
        end
        if ((state_reg == bir_pkg::S_DIVX) && div_done)
        begin
            pos_x_reg <= dmx_zero ? '0 : POS_W'(div_quo);
        end
        if (state_reg == bir_pkg::S_ADDR)
        begin
            top_row_reg <= RW'(iy_c);
            bot_row_reg <= use_bot ? RW'(iy_c + 1'b1) : RW'(iy_c);
            ix0_reg     <= xs ? RW'(sw - 1'b1) : RW'(ix_c);
            ix1_reg     <= xs ? RW'(sw - 1'b1) : RW'(ix_c + 1'b1);
            fx_reg      <= pos_x_reg[FRAC_BITS-1:0];
            fy_reg      <= pos_y_reg[FRAC_BITS-1:0];
            xs_reg      <= xs;
            use_bot_reg <= use_bot;
        end
        rd_tag_reg <= rd_cnt_reg;
        if (rd_vld_reg)
        begin
            p_reg[rd_tag_reg] <= st_rdata;
        end
        if (state_reg == bir_pkg::S_HBLEND)
        begin
            top_v_reg <= h_top;
            bot_v_reg <= h_bot;
        end
        if (state_reg == bir_pkg::S_VMUL)
        begin
            vt_reg <= VW'(ONE - WT_W'(fy_reg)) * VW'(top_v_reg);
            vb_reg <= use_bot_reg ? VW'(fy_reg) * VW'(bot_v_reg) : '0;
        end
        if (state_reg == bir_pkg::S_VSUM)
        begin
            res_reg <= (v_round > RES_W'(255)) ? 8'd255 : pix_t'(v_round);
        end
        if ((state_reg == bir_pkg::S_FIN) && out_free)
        begin
            pixel_out_reg   <= err_reg ? 8'd0 : res_reg;
            range_error_reg <= err_reg;
        end
    end

    assign in_ready    = (state_reg == bir_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign pixel_out   = pixel_out_reg;
    assign range_error = range_error_reg;

endmodule

FILE: rtl/core/bir_divider.sv
module bir_divider #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= numerator;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/bir_store.sv
module bir_store #(
    parameter int DEPTH = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [bir_pkg::PIX_W-1:0]  wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [bir_pkg::PIX_W-1:0]  rdata
);

    logic [bir_pkg::PIX_W-1:0] mem [DEPTH];
    logic [bir_pkg::PIX_W-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bir_checker.sv
module bir_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           opcode,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [bir_pkg::PIX_W-1:0]      pixel_out,
    input logic                           range_error
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(range_error))
        else $error("result word dropped or changed while stalled");

    // an error result carries a zero pixel
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> pixel_out == 8'd0)
        else $error("range error with nonzero pixel");

    // an accepted request takes in_ready low
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == bir_pkg::OP_REQUEST) |=> !in_ready)
        else $error("input taken during a request");

    // a load never produces a result word by itself
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready && (opcode == bir_pkg::OP_LOAD) |=> !out_valid)
        else $error("result word after a load");

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .range_error(range_error)
);

FILE: bench/bilinear_image_resize_test.sv
module bilinear_image_resize_test;

    localparam int SRC_DIM   = 128;
    localparam int DST_DIM   = 1024;
    localparam int NUM_CH    = 4;
    localparam int FRAC      = 12;
    localparam int DRAIN     = 120;
    localparam int MAX_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 250;
    localparam int ROUND_ITEMS  = 25;

    typedef struct packed {
        logic [bir_pkg::PIX_W-1:0] pixel;
        logic                      err;
    } resize_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [bir_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bir_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          opcode;
    logic [bir_pkg::COORD_W-1:0]   coord_x;
    logic [bir_pkg::COORD_W-1:0]   coord_y;
    logic [bir_pkg::CHAN_W-1:0]    channel;
    logic [bir_pkg::PIX_W-1:0]     pixel_in;
    logic                          out_valid;
    logic                          out_ready;
    logic [bir_pkg::PIX_W-1:0]     pixel_out;
    logic                          range_error;

    // model copy of the block state
    logic [7:0]        src_pixels [SRC_DIM*SRC_DIM*NUM_CH];
    logic [7:0]        reg_src_w;
    logic [7:0]        reg_src_h;
    logic [10:0]       reg_dst_w;
    logic [10:0]       reg_dst_h;
    logic [2:0]        reg_nch;
    resize_result_t    expected_pixels [$];
    int                errors;
    int                cycles;
    int                random_sent;

    bilinear_image_resize i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .channel     (channel),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .range_error (range_error)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int pixel_addr(longint unsigned x, longint unsigned y,
                                      longint unsigned c);
        return int'(((c * SRC_DIM) + y) * SRC_DIM + x);
    endfunction

    function automatic longint unsigned scaled_pos(longint unsigned coord,
                                                   longint unsigned src,
                                                   longint unsigned dst);
        if (dst <= 1)
            return 0;
        return ((coord * (src - 1)) << FRAC) / (dst - 1);
    endfunction

    // horizontal blend of one source row, Q.FRAC
    function automatic longint unsigned blend_row(longint unsigned dx, longint unsigned y,
                                                  longint unsigned c, longint unsigned sw,
                                                  longint unsigned dw);
        longint unsigned pos;
        longint unsigned ix;
        longint unsigned fx;
        if (dx == dw - 1 || sw == 1)
            return longint'(src_pixels[pixel_addr(sw - 1, y, c)]) << FRAC;
        pos = scaled_pos(dx, sw, dw);
        ix  = pos >> FRAC;
        fx  = pos & ((64'd1 << FRAC) - 1);
        if (ix + 1 >= sw)
            ix = sw - 2;
        return ((64'd1 << FRAC) - fx) * src_pixels[pixel_addr(ix, y, c)]
               + fx * src_pixels[pixel_addr(ix + 1, y, c)];
    endfunction

    function automatic resize_result_t resize_pixel(longint unsigned x, longint unsigned y,
                                                    longint unsigned c);
        longint unsigned sw;
        longint unsigned sh;
        longint unsigned dw;
        longint unsigned dh;
        longint unsigned nc;
        longint unsigned pos;
        longint unsigned iy;
        longint unsigned fy;
        longint unsigned v;
        longint unsigned r;
        resize_result_t  res;
        sw = clamp_size(reg_src_w, SRC_DIM);
        sh = clamp_size(reg_src_h, SRC_DIM);
        dw = clamp_size(reg_dst_w, DST_DIM);
        dh = clamp_size(reg_dst_h, DST_DIM);
        nc = clamp_size(reg_nch, NUM_CH);
        if (x >= dw || y >= dh || c >= nc)
        begin
            res.pixel = '0;
            res.err   = 1'b1;
            return res;
        end
        pos = scaled_pos(y, sh, dh);
        iy  = pos >> FRAC;
        fy  = pos & ((64'd1 << FRAC) - 1);
        if (iy >= sh)
            iy = sh - 1;
        v = ((64'd1 << FRAC) - fy) * blend_row(x, iy, c, sw, dw);
        if (!(y == dh - 1 || sh == 1) && iy + 1 < sh)
            v += fy * blend_row(x, iy + 1, c, sw, dw);
        r = (v + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        res.pixel = (r > 255) ? 8'd255 : r[7:0];
        res.err   = 1'b0;
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = 1'b1;
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        resize_result_t exp_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word pixel_out=%0d range_error=%0d",
                         $time, pixel_out, range_error);
                errors++;
            end
            else
            begin
                exp_word = expected_pixels.pop_front();
                if (pixel_out !== exp_word.pixel)
                begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, exp_word.pixel, pixel_out);
                    errors++;
                end
                if (range_error !== exp_word.err)
                begin
                    $display("%0t: range_error expected %0d actual %0d",
                             $time, exp_word.err, range_error);
                    errors++;
                end
            end
        end
    end

    // send one input word and update the model when accepted
    task automatic send_word(logic op, int x, int y, int c, int pix);
        int gap;
        longint unsigned sw;
        longint unsigned sh;
        longint unsigned nc;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        opcode   = op;
        coord_x  = bir_pkg::COORD_W'(x);
        coord_y  = bir_pkg::COORD_W'(y);
        channel  = bir_pkg::CHAN_W'(c);
        pixel_in = bir_pkg::PIX_W'(pix);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == bir_pkg::OP_LOAD)
        begin
            sw = clamp_size(reg_src_w, SRC_DIM);
            sh = clamp_size(reg_src_h, SRC_DIM);
            nc = clamp_size(reg_nch, NUM_CH);
            if (x < sw && y < sh && c < nc)
                src_pixels[pixel_addr(x, y, c)] = 8'(pix);
        end
        else
            expected_pixels.insert(expected_pixels.size(), resize_pixel(x, y, c));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [bir_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = bir_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            bir_pkg::CFG_SRC_WIDTH:  reg_src_w = value[7:0];
            bir_pkg::CFG_SRC_HEIGHT: reg_src_h = value[7:0];
            bir_pkg::CFG_DST_WIDTH:  reg_dst_w = value[10:0];
            bir_pkg::CFG_DST_HEIGHT: reg_dst_h = value[10:0];
            bir_pkg::CFG_NUM_CHAN:   reg_nch   = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(int sw, int sh, int dw, int dh, int nc);
        wait_idle();
        write_reg(bir_pkg::CFG_SRC_WIDTH, sw);
        write_reg(bir_pkg::CFG_SRC_HEIGHT, sh);
        write_reg(bir_pkg::CFG_DST_WIDTH, dw);
        write_reg(bir_pkg::CFG_DST_HEIGHT, dh);
        write_reg(bir_pkg::CFG_NUM_CHAN, nc);
    endtask

    // fill every entry the current sizes can read
    task automatic load_image();
        int sw;
        int sh;
        int nc;
        sw = int'(clamp_size(reg_src_w, SRC_DIM));
        sh = int'(clamp_size(reg_src_h, SRC_DIM));
        nc = int'(clamp_size(reg_nch, NUM_CH));
        for (int c = 0; c < nc; c++)
            for (int y = 0; y < sh; y++)
                for (int x = 0; x < sw; x++)
                    send_word(bir_pkg::OP_LOAD, x, y, c, $urandom_range(0, 255));
    endtask

    // only out-of-range requests are legal before any load
    task automatic test_reset_sizes();
        send_word(bir_pkg::OP_REQUEST, 416, 0, 0, 8'hFF);
        send_word(bir_pkg::OP_REQUEST, 1023, 1023, 3, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 0, 3, 0);
        send_word(bir_pkg::OP_LOAD, 200, 0, 0, 8'h55);
    endtask

    task automatic test_corners();
        set_sizes(4, 3, 7, 5, 4);
        load_image();
        send_word(bir_pkg::OP_REQUEST, 0, 0, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 6, 0, 1, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 4, 2, 0);
        send_word(bir_pkg::OP_REQUEST, 6, 4, 3, 0);
        send_word(bir_pkg::OP_REQUEST, 3, 2, 1, 8'hFF);
        send_word(bir_pkg::OP_REQUEST, 7, 0, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 5, 0, 0);
        send_word(bir_pkg::OP_LOAD, 4, 0, 0, 8'hAA);
        send_word(bir_pkg::OP_LOAD, 0, 3, 0, 8'hAA);
        send_word(bir_pkg::OP_REQUEST, 3, 1, 0, 0);
    endtask

    // zero register values clamp to one
    task automatic test_unit_sizes();
        set_sizes(0, 0, 0, 0, 0);
        load_image();
        send_word(bir_pkg::OP_REQUEST, 0, 0, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 1, 0, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 0, 1, 0);
    endtask

    task automatic test_wide_source();
        set_sizes(255, 1, 2047, 2, 1);
        load_image();
        send_word(bir_pkg::OP_REQUEST, 1023, 1, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 511, 0, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 1, 1, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 1000, 2, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 0, 1, 0);
    endtask

    task automatic test_tall_source();
        set_sizes(1, 255, 3, 1000, 1);
        load_image();
        send_word(bir_pkg::OP_REQUEST, 1, 999, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 517, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 2, 998, 0, 0);
        send_word(bir_pkg::OP_REQUEST, 0, 0, 1, 0);
    endtask

    task automatic test_random();
        int sw;
        int sh;
        int dw;
        int dh;
        int nc;
        int roll;
        while (random_sent < RANDOM_ITEMS)
        begin
            sw = $urandom_range(0, 4);
            sh = $urandom_range(0, 4);
            dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 20);
            dh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 20);
            nc = $urandom_range(0, 7);
            set_sizes(sw, sh, dw, dh, nc);
            load_image();
            sw = int'(clamp_size(reg_src_w, SRC_DIM));
            sh = int'(clamp_size(reg_src_h, SRC_DIM));
            dw = int'(clamp_size(reg_dst_w, DST_DIM));
            dh = int'(clamp_size(reg_dst_h, DST_DIM));
            nc = int'(clamp_size(reg_nch, NUM_CH));
            for (int i = 0; i < ROUND_ITEMS; i++)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    send_word(bir_pkg::OP_REQUEST, $urandom_range(0, dw - 1),
                              $urandom_range(0, dh - 1),
                              $urandom_range(0, nc - 1), $urandom_range(0, 255));
                else if (roll < 8)
                    send_word(bir_pkg::OP_REQUEST, $urandom_range(0, 1023),
                              $urandom_range(0, 1023),
                              $urandom_range(0, 3), $urandom_range(0, 255));
                else if (roll < 9)
                    send_word(bir_pkg::OP_LOAD, $urandom_range(0, sw - 1),
                              $urandom_range(0, sh - 1),
                              $urandom_range(0, nc - 1), $urandom_range(0, 255));
                else
                    send_word(bir_pkg::OP_LOAD, $urandom_range(0, 1023),
                              $urandom_range(0, 1023),
                              $urandom_range(0, 3), $urandom_range(0, 255));
                random_sent++;
            end
        end
    endtask

    initial
    begin
        errors      = 0;
        cycles      = 0;
        random_sent = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = bir_pkg::OP_LOAD;
        coord_x     = '0;
        coord_y     = '0;
        channel     = '0;
        pixel_in    = '0;
        reg_src_w   = 8'd128;
        reg_src_h   = 8'd128;
        reg_dst_w   = 11'd416;
        reg_dst_h   = 11'd416;
        reg_nch     = 3'd3;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_sizes();
        test_corners();
        test_unit_sizes();
        test_wide_source();
        test_tall_source();
        test_random();
        wait_idle();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
